/* sv/mesh_aabb_all_pairs_broad_phase_assert.svh */
// Assertion macros shared by the block's checkers.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MESH_AABB_ALL_PAIRS_BROAD_PHASE_ASSERT_SVH
`define MESH_AABB_ALL_PAIRS_BROAD_PHASE_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define MABP_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the next cycle.
`define MABP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/mabp_pkg.sv */
package mabp_pkg;

  // Fixed field widths of the ports
  localparam int POS_W      = 32;
  localparam int ID_W       = 3;
  localparam int DIST_W     = 31;
  localparam int MCNT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int AXES       = 3;

  // Results per emit command are capped
  localparam int RESULT_CAP = 28;
  localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_ACT_DIST   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MESH_COUNT = 1'b1;

endpackage

/* sv/mesh_aabb_all_pairs_broad_phase.sv */
// Channel   Direction  Handshake               Word
// in        sink       in_valid_i / in_stall_o  opcode, mesh_id, pos_x/y/z
// out       source     out_valid_o / out_stall_i pair_found, meshes, widened box, last
// cfg       sink       cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// Vertex words stream at one per cycle while no emit stalls the input: read box at accept,
// merge and write back next cycle. Emit walks the pairs over the single box memory read port:
// it reads and widens the box of each nonempty mesh a, then reads, widens and compares that of
// every later nonempty b, then ends the walk and loads the last word, and may stall on output.
// in_stall_o stays high from an emit until its last word is loaded into the output register.
// Reset clears the nonempty flags and config; box memory is not cleared (no clearing pass).
module mesh_aabb_all_pairs_broad_phase #(
  parameter int MAX_MESHES  = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [mabp_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [mabp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [mabp_pkg::ID_W-1:0]           mesh_id_i,
  input  logic signed [mabp_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [mabp_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [mabp_pkg::POS_W-1:0]   pos_z_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pair_found_o,
  output logic [mabp_pkg::ID_W-1:0]           first_mesh_o,
  output logic [mabp_pkg::ID_W-1:0]           second_mesh_o,
  output logic signed [mabp_pkg::POS_W-1:0]   lo_x_o,
  output logic signed [mabp_pkg::POS_W-1:0]   lo_y_o,
  output logic signed [mabp_pkg::POS_W-1:0]   lo_z_o,
  output logic signed [mabp_pkg::POS_W-1:0]   hi_x_o,
  output logic signed [mabp_pkg::POS_W-1:0]   hi_y_o,
  output logic signed [mabp_pkg::POS_W-1:0]   hi_z_o,
  output logic                                last_o
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = $clog2(MAX_MESHES);
  // Width for saturating arithmetic: holds any coordinate plus or minus the distance
  localparam int SW = ((CW > mabp_pkg::POS_W) ? CW : mabp_pkg::POS_W) + 1;
  localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;
  localparam int HI = mabp_pkg::AXES;

  // Box entry: elements 0..2 hold the minima, 3..5 the maxima
  typedef logic [2*mabp_pkg::AXES-1:0][CW-1:0] box_t;
  typedef logic [mabp_pkg::AXES-1:0][CW-1:0]   pos_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_CHK,
    S_A_WID,
    S_B_CHK,
    S_B_WID,
    S_CMP,
    S_FIN
  } state_e;

  function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic [CW-1:0] r;
    if (v > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic box_t widen(input box_t b, input logic [mabp_pkg::DIST_W-1:0] d);
    box_t w;
    logic signed [SW-1:0] ds;
    ds = signed'(SW'(d));
    for (int k = 0; k < mabp_pkg::AXES; k++) begin
      w[k]    = sat_coord(SW'(signed'(b[k])) - ds);
      w[k+HI] = sat_coord(SW'(signed'(b[k+HI])) + ds);
    end
    return w;
  endfunction

  // Configuration
  logic [mabp_pkg::DIST_W-1:0] act_dist_q;
  logic [mabp_pkg::MCNT_W-1:0] mesh_count_q;
  logic [mabp_pkg::MCNT_W-1:0] cnt;

  // Box memory and its read port
  box_t            box_mem_q [MAX_MESHES];
  box_t            rdata_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  // Vertex merge stage and write-back forwarding
  logic            v1_v_q;
  logic [AW-1:0]   v1_id_q;
  pos_t            v1_pos_q;
  logic            fwd_v_q;
  logic [AW-1:0]   fwd_id_q;
  box_t            fwd_box_q;
  box_t            merge_base;
  box_t            merge_box;

  logic [MAX_MESHES-1:0] ne_q;

  // Walk
  state_e                           state_q;
  logic [mabp_pkg::MCNT_W-1:0]      a_q;
  logic [mabp_pkg::MCNT_W-1:0]      b_q;
  logic [mabp_pkg::RES_CNT_W-1:0]   n_q;
  box_t                             box_a_q;
  box_t                             box_b_q;
  logic                             ovl;

  // Pending word and output register
  logic                       pend_v_q;
  logic [mabp_pkg::ID_W-1:0]  pend_a_q;
  logic [mabp_pkg::ID_W-1:0]  pend_b_q;
  box_t                       pend_box_q;
  logic                       out_v_q;
  logic                       out_found_q;
  logic                       out_last_q;
  logic [mabp_pkg::ID_W-1:0]  out_a_q;
  logic [mabp_pkg::ID_W-1:0]  out_b_q;
  box_t                       out_box_q;

  logic in_acc;
  logic vtx_acc;
  logic emit_acc;
  logic out_free;
  logic a_rd;
  logic b_rd;
  logic cmp_go;
  logic cmp_hit;
  logic push_pend;
  logic fin_go;
  pos_t in_pos;

  assign cnt = (mesh_count_q > mabp_pkg::MCNT_W'(MAX_MESHES)) ?
               mabp_pkg::MCNT_W'(MAX_MESHES) : mesh_count_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // Drop vertices of meshes out of use
  assign vtx_acc    = in_acc && (opcode_i == mabp_pkg::OP_ADD) &&
                      (mabp_pkg::MCNT_W'(mesh_id_i) < cnt);
  assign emit_acc   = in_acc && (opcode_i == mabp_pkg::OP_EMIT);

  assign in_pos[0] = sat_coord(SW'(signed'(pos_x_i)));
  assign in_pos[1] = sat_coord(SW'(signed'(pos_y_i)));
  assign in_pos[2] = sat_coord(SW'(signed'(pos_z_i)));

  // Merge: take the box written last cycle if it hits the same mesh
  always_comb begin
    merge_base = (fwd_v_q && (fwd_id_q == v1_id_q)) ? fwd_box_q : rdata_q;
    for (int k = 0; k < mabp_pkg::AXES; k++) begin
      if (!ne_q[v1_id_q]) begin
        merge_box[k]    = v1_pos_q[k];
        merge_box[k+HI] = v1_pos_q[k];
      end else begin
        merge_box[k]    = ($signed(v1_pos_q[k]) < $signed(merge_base[k])) ?
                          v1_pos_q[k] : merge_base[k];
        merge_box[k+HI] = ($signed(v1_pos_q[k]) > $signed(merge_base[k+HI])) ?
                          v1_pos_q[k] : merge_base[k+HI];
      end
    end
  end

  // Widened boxes touch or overlap on every axis
  always_comb begin
    ovl = 1'b1;
    for (int k = 0; k < mabp_pkg::AXES; k++) begin
      if (($signed(box_a_q[k+HI]) < $signed(box_b_q[k])) ||
          ($signed(box_b_q[k+HI]) < $signed(box_a_q[k]))) begin
        ovl = 1'b0;
      end
    end
  end

  assign out_free  = !out_v_q || !out_stall_i;
  assign a_rd      = (state_q == S_A_CHK) && (a_q < cnt) && ne_q[a_q[AW-1:0]];
  assign b_rd      = (state_q == S_B_CHK) && (b_q < cnt) && ne_q[b_q[AW-1:0]];
  // A hit with a word already pending must first move it to the output register
  assign cmp_go    = (state_q == S_CMP) && (!ovl || !pend_v_q || out_free);
  assign cmp_hit   = cmp_go && ovl;
  assign push_pend = cmp_hit && pend_v_q;
  assign fin_go    = (state_q == S_FIN) && out_free;

  // Share the read port between vertex accept and the walk
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(mesh_id_i);
    if (state_q == S_IDLE) begin
      rd_en = vtx_acc;
    end else if (state_q == S_A_CHK) begin
      rd_en   = a_rd;
      rd_addr = a_q[AW-1:0];
    end else if (state_q == S_B_CHK) begin
      rd_en   = b_rd;
      rd_addr = b_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= box_mem_q[rd_addr];
    end
    if (v1_v_q) begin
      box_mem_q[v1_id_q] <= merge_box;
    end
  end

  // Control state and walk sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_dist_q   <= '0;
      mesh_count_q <= '0;
      v1_v_q       <= 1'b0;
      fwd_v_q      <= 1'b0;
      ne_q         <= '0;
      a_q          <= '0;
      b_q          <= '0;
      n_q          <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          mabp_pkg::REG_ACT_DIST:   act_dist_q   <= cfg_wdata_i;
          mabp_pkg::REG_MESH_COUNT: mesh_count_q <= cfg_wdata_i[mabp_pkg::MCNT_W-1:0];
          default: ;
        endcase
      end

      v1_v_q  <= vtx_acc;
      fwd_v_q <= v1_v_q;
      if (v1_v_q) begin
        ne_q[v1_id_q] <= 1'b1;
      end

      if (push_pend || fin_go) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (emit_acc) begin
            a_q     <= '0;
            n_q     <= '0;
            state_q <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (a_q >= cnt) begin
            state_q <= S_FIN;
          end else if (!a_rd) begin
            a_q <= a_q + 1'b1;
          end else begin
            state_q <= S_A_WID;
          end
        end
        S_A_WID: begin
          b_q     <= a_q + 1'b1;
          state_q <= S_B_CHK;
        end
        S_B_CHK: begin
          if (b_q >= cnt) begin
            a_q     <= a_q + 1'b1;
            state_q <= S_A_CHK;
          end else if (!b_rd) begin
            b_q <= b_q + 1'b1;
          end else begin
            state_q <= S_B_WID;
          end
        end
        S_B_WID: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp_go) begin
            if (cmp_hit) begin
              pend_v_q <= 1'b1;
              n_q      <= n_q + 1'b1;
            end
            if (cmp_hit && (n_q == mabp_pkg::RES_CNT_W'(mabp_pkg::RESULT_CAP - 1))) begin
              state_q <= S_FIN;
            end else begin
              b_q     <= b_q + 1'b1;
              state_q <= S_B_CHK;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            pend_v_q <= 1'b0;
            ne_q     <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (vtx_acc) begin
      v1_id_q  <= AW'(mesh_id_i);
      v1_pos_q <= in_pos;
    end
    if (v1_v_q) begin
      fwd_id_q  <= v1_id_q;
      fwd_box_q <= merge_box;
    end
    if (state_q == S_A_WID) begin
      box_a_q <= widen(rdata_q, act_dist_q);
    end
    if (state_q == S_B_WID) begin
      box_b_q <= widen(rdata_q, act_dist_q);
    end
    if (push_pend) begin
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
      out_a_q     <= pend_a_q;
      out_b_q     <= pend_b_q;
      out_box_q   <= pend_box_q;
    end
    if (cmp_hit) begin
      pend_a_q   <= mabp_pkg::ID_W'(a_q);
      pend_b_q   <= mabp_pkg::ID_W'(b_q);
      pend_box_q <= box_a_q;
    end
    if (fin_go) begin
      out_last_q <= 1'b1;
      if (pend_v_q) begin
        out_found_q <= 1'b1;
        out_a_q     <= pend_a_q;
        out_b_q     <= pend_b_q;
        out_box_q   <= pend_box_q;
      end else begin
        // End marker when nothing overlapped
        out_found_q <= 1'b0;
        out_a_q     <= '0;
        out_b_q     <= '0;
        out_box_q   <= '0;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign pair_found_o  = out_found_q;
  assign first_mesh_o  = out_a_q;
  assign second_mesh_o = out_b_q;
  assign lo_x_o        = mabp_pkg::POS_W'(out_box_q[0]);
  assign lo_y_o        = mabp_pkg::POS_W'(out_box_q[1]);
  assign lo_z_o        = mabp_pkg::POS_W'(out_box_q[2]);
  assign hi_x_o        = mabp_pkg::POS_W'(out_box_q[HI]);
  assign hi_y_o        = mabp_pkg::POS_W'(out_box_q[HI+1]);
  assign hi_z_o        = mabp_pkg::POS_W'(out_box_q[HI+2]);
  assign last_o        = out_last_q;

endmodule

/* sv/mabp_checker.sv */
`include "mesh_aabb_all_pairs_broad_phase_assert.svh"

module mabp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                opcode_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                pair_found_o,
  input logic [mabp_pkg::ID_W-1:0]           first_mesh_o,
  input logic [mabp_pkg::ID_W-1:0]           second_mesh_o,
  input logic signed [mabp_pkg::POS_W-1:0]   lo_x_o,
  input logic signed [mabp_pkg::POS_W-1:0]   lo_y_o,
  input logic signed [mabp_pkg::POS_W-1:0]   lo_z_o,
  input logic signed [mabp_pkg::POS_W-1:0]   hi_x_o,
  input logic signed [mabp_pkg::POS_W-1:0]   hi_y_o,
  input logic signed [mabp_pkg::POS_W-1:0]   hi_z_o,
  input logic                                last_o
);

  logic emit_acc;
  logic out_hold;
  logic marker_zero;
  logic [2*mabp_pkg::ID_W+6*mabp_pkg::POS_W+1:0] out_word;

  assign emit_acc    = in_valid_i && !in_stall_o && (opcode_i == mabp_pkg::OP_EMIT);
  assign out_hold    = out_valid_o && out_stall_i;
  assign out_word    = {pair_found_o, first_mesh_o, second_mesh_o, lo_x_o, lo_y_o, lo_z_o,
                        hi_x_o, hi_y_o, hi_z_o, last_o};
  assign marker_zero = last_o && (first_mesh_o == '0) && (second_mesh_o == '0) &&
                       (lo_x_o == '0) && (lo_y_o == '0) && (lo_z_o == '0) &&
                       (hi_x_o == '0) && (hi_y_o == '0) && (hi_z_o == '0);

  // Hold a stalled output word
  `MABP_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_word), "stalled output word changed")

  // End marker carries zero fields and closes the emit
  `MABP_ASSERT_NOW(a_marker, out_valid_o && !pair_found_o, marker_zero, "end marker not clean")

  // Pairs come with the lower mesh first
  `MABP_ASSERT_NOW(a_pair_order, out_valid_o && pair_found_o, first_mesh_o < second_mesh_o, "pair out of order")

  // Stall the input while an emit walks the pairs
  `MABP_ASSERT_NEXT(a_emit_stall, emit_acc, in_stall_o, "input not stalled after emit")

endmodule

bind mesh_aabb_all_pairs_broad_phase mabp_checker u_mabp_checker (.*);
